FILE: hdl/nfa_subset_construction_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the subset construction block.
// Both macros compile to nothing when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef NFA_SUBSET_CONSTRUCTION_MACROS_SVH
`define NFA_SUBSET_CONSTRUCTION_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge out of reset.
`define NSC_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nsc invariant violated");

// A condition that must hold whenever the antecedent holds.
`define NSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsc implication violated");

`else

`define NSC_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define NSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/nsc_pkg.sv
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants of the NFA subset construction block.
// ---------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

    // Field widths fixed by the block definition.
    localparam int SET_W      = 3;
    localparam int ROW_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_ROWS   = 3;
    localparam int SUBSETS    = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_FROM_STATE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_FROM_STATE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_FROM_STATE2 = 2'd2;

    // Reset values of the successor rows.
    localparam logic [ROW_W-1:0] RST_NEXT_FROM_STATE0 = 6'd25;
    localparam logic [ROW_W-1:0] RST_NEXT_FROM_STATE1 = 6'd36;
    localparam logic [ROW_W-1:0] RST_NEXT_FROM_STATE2 = 6'd0;

    // First and last subset index of a scan.
    localparam logic [SET_W-1:0] FIRST_SUBSET = 3'd1;
    localparam logic [SET_W-1:0] LAST_SUBSET  = 3'd7;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPLORE,
        ST_EMIT
    } nsc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // load a new start subset and clear the sets
        logic explore;   // process the subset at the scan index
        logic emit;      // emit the subset at the scan index if reached
    } nsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_empty;  // masked start subset is empty
        logic idx_last;     // scan index is at the final subset
        logic changed_now;  // this pass explored at least one subset
        logic cur_reached;  // subset at the scan index is reached
        logic out_busy;     // output register holds a row not yet taken
    } nsc_status_t;

endpackage

`default_nettype wire

FILE: hdl/nsc_ifs.sv
// ---------------------------------------------------------------------------
// nsc_ifs
// Valid/ready channel interfaces for the start subset and the result rows.
// ---------------------------------------------------------------------------
`default_nettype none

// Start subset channel.
interface nsc_start_if;
    logic                        valid;
    logic                        ready;
    logic [nsc_pkg::SET_W-1:0]   start_subset;

    modport source (output valid, output start_subset, input ready);
    modport sink   (input valid, input start_subset, output ready);
endinterface

// Result row channel.
interface nsc_row_if;
    logic                        valid;
    logic                        ready;
    logic [nsc_pkg::SET_W-1:0]   subset;
    logic [nsc_pkg::SET_W-1:0]   next_on_zero;
    logic [nsc_pkg::SET_W-1:0]   next_on_one;
    logic                        last_row;

    modport source (output valid, output subset, output next_on_zero,
                    output next_on_one, output last_row, input ready);
    modport sink   (input valid, input subset, input next_on_zero,
                    input next_on_one, input last_row, output ready);
endinterface

`default_nettype wire

FILE: hdl/nfa_subset_construction.sv
// ---------------------------------------------------------------------------
// nfa_subset_construction
// NFA to DFA subset construction over a two-symbol NFA of up to three states.
// ---------------------------------------------------------------------------
// Each start subset transaction produces one row per nonempty subset
// reachable from it, in ascending subset order, with the successor subsets
// on symbol 0 and symbol 1; the final row carries last_row, and an empty
// start subset produces no rows and leaves the block idle. The
// datapath scans the seven nonempty subsets one per clock, except that the
// emission pass holds while a reached row waits for a busy output register:
// exploration passes repeat until a pass finds nothing new (at least two
// and at most eight passes), then one emission pass follows. The start
// channel is ready only while the block is idle; the last row may still sit
// in the output register when the next start subset is taken. Successor
// rows are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// ---------------------------------------------------------------------------
`default_nettype none

module nfa_subset_construction #(
    parameter int NFA_STATES = 3
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nsc_pkg::ROW_W-1:0]     cfg_data,
    nsc_start_if.sink                          start,
    nsc_row_if.source                          rows
);

    // States at or above NFA_STATES, and above the third, are ignored.
    localparam int MASK_BITS = (NFA_STATES > nsc_pkg::SET_W) ? nsc_pkg::SET_W : NFA_STATES;
    localparam logic [nsc_pkg::SET_W-1:0] STATE_MASK =
        nsc_pkg::SET_W'((1 << MASK_BITS) - 1);

    nsc_pkg::nsc_cmd_t    cmd;
    nsc_pkg::nsc_status_t status;

    // Controller.
    nsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start.valid),
        .in_ready (start.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    nsc_datapath #(
        .STATE_MASK (STATE_MASK)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_subset (start.start_subset),
        .cmd          (cmd),
        .status       (status),
        .rows         (rows)
    );

endmodule

`default_nettype wire

FILE: hdl/nsc_datapath.sv
// ---------------------------------------------------------------------------
// nsc_datapath
// Successor rows, reached and explored sets, scan index and output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nfa_subset_construction_macros.svh"

module nsc_datapath #(
    parameter logic [nsc_pkg::SET_W-1:0] STATE_MASK = 3'b111
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nsc_pkg::ROW_W-1:0]     cfg_data,
    input  wire logic [nsc_pkg::SET_W-1:0]     start_subset,
    input  wire nsc_pkg::nsc_cmd_t             cmd,
    output nsc_pkg::nsc_status_t               status,
    nsc_row_if.source                          rows
);

    logic [nsc_pkg::ROW_W-1:0]   row_reg [nsc_pkg::NUM_ROWS];
    logic [nsc_pkg::SUBSETS-1:0] reached_reg, reached_next;
    logic [nsc_pkg::SUBSETS-1:0] explored_reg, explored_next;
    logic [nsc_pkg::SET_W-1:0]   idx_reg, idx_next;
    logic                        changed_reg, changed_next;
    logic                        out_valid_reg, out_valid_next;
    logic [nsc_pkg::SET_W-1:0]   out_subset_reg;
    logic [nsc_pkg::SET_W-1:0]   out_zero_reg;
    logic [nsc_pkg::SET_W-1:0]   out_one_reg;
    logic                        out_last_reg;

    logic [nsc_pkg::SET_W-1:0]   start_m;
    logic [nsc_pkg::SET_W-1:0]   cur_m;
    logic [nsc_pkg::SET_W-1:0]   succ0;
    logic [nsc_pkg::SET_W-1:0]   succ1;
    logic                        hit;
    logic                        is_last;
    logic                        load_out;

    // Configuration registers: one successor row per NFA state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= nsc_pkg::RST_NEXT_FROM_STATE0;
            row_reg[1] <= nsc_pkg::RST_NEXT_FROM_STATE1;
            row_reg[2] <= nsc_pkg::RST_NEXT_FROM_STATE2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsc_pkg::CFG_NEXT_FROM_STATE0: row_reg[0] <= cfg_data;
                nsc_pkg::CFG_NEXT_FROM_STATE1: row_reg[1] <= cfg_data;
                nsc_pkg::CFG_NEXT_FROM_STATE2: row_reg[2] <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Successors of the subset at the scan index: OR of the member rows.
    always_comb
    begin
        cur_m = idx_reg & STATE_MASK;
        succ0 = '0;
        succ1 = '0;
        for (int k = 0; k < nsc_pkg::NUM_ROWS; k++)
        begin
            if (cur_m[k])
            begin
                succ0 = succ0 | row_reg[k][2:0];
                succ1 = succ1 | row_reg[k][5:3];
            end
        end
        succ0 = succ0 & STATE_MASK;
        succ1 = succ1 & STATE_MASK;
    end

    assign start_m  = start_subset & STATE_MASK;
    assign hit      = reached_reg[idx_reg] && !explored_reg[idx_reg];
    assign is_last  = (reached_reg & (8'hFE << idx_reg)) == '0;
    assign load_out = cmd.emit && reached_reg[idx_reg];

    // Next values of the sets, the scan index and the pass flag.
    always_comb
    begin
        reached_next  = reached_reg;
        explored_next = explored_reg;
        idx_next      = idx_reg;
        changed_next  = changed_reg;
        if (cmd.take)
        begin
            reached_next  = '0;
            explored_next = '0;
            if (start_m != '0)
            begin
                reached_next[start_m] = 1'b1;
            end
            idx_next     = nsc_pkg::FIRST_SUBSET;
            changed_next = 1'b0;
        end
        else if (cmd.explore)
        begin
            if (hit)
            begin
                explored_next[idx_reg] = 1'b1;
                if (succ0 != '0)
                begin
                    reached_next[succ0] = 1'b1;
                end
                if (succ1 != '0)
                begin
                    reached_next[succ1] = 1'b1;
                end
            end
            if (idx_reg == nsc_pkg::LAST_SUBSET)
            begin
                idx_next     = nsc_pkg::FIRST_SUBSET;
                changed_next = 1'b0;
            end
            else
            begin
                idx_next     = idx_reg + 3'd1;
                changed_next = changed_reg | hit;
            end
        end
        else if (cmd.emit)
        begin
            if (idx_reg == nsc_pkg::LAST_SUBSET)
            begin
                idx_next = nsc_pkg::FIRST_SUBSET;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // Output register valid flag.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rows.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg   <= '0;
            explored_reg  <= '0;
            idx_reg       <= nsc_pkg::FIRST_SUBSET;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reached_reg   <= reached_next;
            explored_reg  <= explored_next;
            idx_reg       <= idx_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output row payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_subset_reg <= idx_reg;
            out_zero_reg   <= succ0;
            out_one_reg    <= succ1;
            out_last_reg   <= is_last;
        end
    end

    // Status toward the controller.
    assign status.start_empty = (start_m == '0);
    assign status.idx_last    = (idx_reg == nsc_pkg::LAST_SUBSET);
    assign status.changed_now = changed_reg | hit;
    assign status.cur_reached = reached_reg[idx_reg];
    assign status.out_busy    = out_valid_reg && !rows.ready;

    assign rows.valid        = out_valid_reg;
    assign rows.subset       = out_subset_reg;
    assign rows.next_on_zero = out_zero_reg;
    assign rows.next_on_one  = out_one_reg;
    assign rows.last_row     = out_last_reg;

    // A subset is only explored after it has been reached.
    `NSC_ASSERT_ALWAYS(a_explored_within_reached, clk, rst_n,
        (explored_reg & ~reached_reg) == '0)
    // The empty subset is never reached and the scan never points at it.
    `NSC_ASSERT_ALWAYS(a_no_empty_subset, clk, rst_n,
        !reached_reg[0] && (idx_reg != '0))
    // A row is only loaded when the output register is free or draining.
    `NSC_ASSERT_IMPLY(a_no_overwrite, clk, rst_n,
        load_out, !out_valid_reg || rows.ready)

endmodule

`default_nettype wire

FILE: hdl/nsc_ctrl.sv
// ---------------------------------------------------------------------------
// nsc_ctrl
// Controller state machine: accepts a start subset and, unless it is empty,
// runs exploration passes until closure and then sequences the row emission.
// ---------------------------------------------------------------------------
`default_nettype none

module nsc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire nsc_pkg::nsc_status_t  status,
    output nsc_pkg::nsc_cmd_t          cmd
);

    nsc_pkg::nsc_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nsc_pkg::ST_IDLE:
            begin
                if (in_valid && !status.start_empty)
                begin
                    state_next = nsc_pkg::ST_EXPLORE;
                end
            end
            nsc_pkg::ST_EXPLORE:
            begin
                // Closure is reached after a full pass that explored nothing.
                if (status.idx_last && !status.changed_now)
                begin
                    state_next = nsc_pkg::ST_EMIT;
                end
            end
            nsc_pkg::ST_EMIT:
            begin
                if (status.idx_last && !(status.cur_reached && status.out_busy))
                begin
                    state_next = nsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            nsc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            nsc_pkg::ST_EXPLORE:
            begin
                cmd.explore = 1'b1;
            end
            nsc_pkg::ST_EMIT:
            begin
                // Hold the scan while a reached row waits for the output register.
                cmd.emit = !(status.cur_reached && status.out_busy);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
